FILE: design/thumb_alu_execute_top_macros.svh
// assertion macros for the thumb alu execute block
`ifndef THUMB_ALU_EXECUTE_TOP_MACROS_SVH
`define THUMB_ALU_EXECUTE_TOP_MACROS_SVH

`ifndef NO_ASSERTIONS

// antecedent implies consequent in the same cycle
`define THALU_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// antecedent implies consequent in the next cycle
`define THALU_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`else

`define THALU_ASSERT_NOW(label, clk, rst, ante, cons, msg)
`define THALU_ASSERT_NEXT(label, clk, rst, ante, cons, msg)

`endif

`endif

FILE: design/thalu_pkg.sv
// shared types, constants and decode helpers for the thumb alu execute block
package thalu_pkg;

   localparam int DATA_W    = 32;
   localparam int REG_COUNT = 8;
   localparam int REG_IDX_W = $clog2(REG_COUNT);
   localparam int INSTR_W   = 16;
   localparam int AMT_W     = 8;
   localparam int IMM3_W    = 3;
   localparam int IMM8_W    = 8;

   // opcode prefixes of the supported formats
   localparam logic [2:0] PFX_SHIFT   = 3'b000;
   localparam logic [4:0] PFX_ADD_SUB = 5'b00011;
   localparam logic [2:0] PFX_IMM8    = 3'b001;
   localparam logic [5:0] PFX_ALU     = 6'b010000;

   typedef enum logic [2:0] {
      FMT_NONE      = 3'd0,
      FMT_SHIFT_IMM = 3'd1,
      FMT_ADD_SUB   = 3'd2,
      FMT_IMM8      = 3'd3,
      FMT_ALU       = 3'd4
   } format_type;

   typedef enum logic [1:0] {
      SHIFT_LSL = 2'd0,
      SHIFT_LSR = 2'd1,
      SHIFT_ASR = 2'd2,
      SHIFT_ROR = 2'd3
   } shift_kind_type;

   typedef enum logic [1:0] {
      IMM_MOV = 2'd0,
      IMM_CMP = 2'd1,
      IMM_ADD = 2'd2,
      IMM_SUB = 2'd3
   } imm_op_type;

   typedef enum logic [3:0] {
      ALU_AND = 4'd0,
      ALU_EOR = 4'd1,
      ALU_LSL = 4'd2,
      ALU_LSR = 4'd3,
      ALU_ASR = 4'd4,
      ALU_ADC = 4'd5,
      ALU_SBC = 4'd6,
      ALU_ROR = 4'd7,
      ALU_TST = 4'd8,
      ALU_NEG = 4'd9,
      ALU_CMP = 4'd10,
      ALU_CMN = 4'd11,
      ALU_ORR = 4'd12,
      ALU_MUL = 4'd13,
      ALU_BIC = 4'd14,
      ALU_MVN = 4'd15
   } alu_op_type;

   typedef struct packed {
      logic n;
      logic z;
      logic c;
      logic v;
   } flags_type;

   typedef struct packed {
      logic                 executed;
      logic                 written;
      logic [REG_IDX_W-1:0] dest_index;
      logic [DATA_W-1:0]    value;
      flags_type            flags;
   } exec_result_type;

   function automatic format_type decode_format(input logic [INSTR_W-1:0] ins);
      format_type fmt;
      fmt = FMT_NONE;
      if (ins[15:11] == PFX_ADD_SUB) begin
         fmt = FMT_ADD_SUB;
      end else if (ins[15:13] == PFX_SHIFT) begin
         fmt = FMT_SHIFT_IMM;
      end else if (ins[15:13] == PFX_IMM8) begin
         fmt = FMT_IMM8;
      end else if (ins[15:10] == PFX_ALU) begin
         fmt = FMT_ALU;
      end
      return fmt;
   endfunction

   // second register read: rn for add/sub, rd for immediate and alu ops
   function automatic logic [REG_IDX_W-1:0] port_b_index(input logic [INSTR_W-1:0] ins);
      logic [REG_IDX_W-1:0] idx;
      case (decode_format(ins))
         FMT_ADD_SUB: idx = ins[8:6];
         FMT_IMM8:    idx = ins[10:8];
         default:     idx = ins[2:0];
      endcase
      return idx;
   endfunction

endpackage

FILE: design/thalu_shifter.sv
// barrel shifter with arm carry-out rules
module thalu_shifter (
   input  thalu_pkg::shift_kind_type          kind,
   input  logic [thalu_pkg::AMT_W-1:0]        amount,
   input  logic [thalu_pkg::DATA_W-1:0]       value,
   input  logic                               carry_in,
   output logic [thalu_pkg::DATA_W-1:0]       value_out,
   output logic                               carry_out
);

   localparam int CNT_W = $clog2(thalu_pkg::DATA_W) + 1;
   localparam int ROT_W = $clog2(thalu_pkg::DATA_W);
   localparam logic [thalu_pkg::AMT_W-1:0] FULL = thalu_pkg::AMT_W'(thalu_pkg::DATA_W);

   logic [CNT_W-1:0]                 amt_sat;
   logic                             over;
   logic [thalu_pkg::DATA_W:0]       lsl_wide;
   logic [thalu_pkg::DATA_W:0]       lsr_wide;
   logic signed [thalu_pkg::DATA_W:0] asr_wide;
   logic [2*thalu_pkg::DATA_W-1:0]   ror_wide;
   logic [thalu_pkg::DATA_W-1:0]     ror_res;

   // past the word width asr acts as full width, lsl/lsr give zero, ror wraps
   assign over     = amount > FULL;
   assign amt_sat  = over ? CNT_W'(thalu_pkg::DATA_W) : amount[CNT_W-1:0];
   assign lsl_wide = {1'b0, value} << amt_sat;
   assign lsr_wide = {value, 1'b0} >> amt_sat;
   assign asr_wide = $signed({value, 1'b0}) >>> amt_sat;
   assign ror_wide = {value, value} >> amount[ROT_W-1:0];
   assign ror_res  = ror_wide[thalu_pkg::DATA_W-1:0];

   always_comb begin
      value_out = value;
      carry_out = carry_in;
      if (amount != '0) begin
         case (kind)
            thalu_pkg::SHIFT_LSL: begin
               value_out = over ? '0 : lsl_wide[thalu_pkg::DATA_W-1:0];
               carry_out = over ? 1'b0 : lsl_wide[thalu_pkg::DATA_W];
            end
            thalu_pkg::SHIFT_LSR: begin
               value_out = over ? '0 : lsr_wide[thalu_pkg::DATA_W:1];
               carry_out = over ? 1'b0 : lsr_wide[0];
            end
            thalu_pkg::SHIFT_ASR: begin
               value_out = asr_wide[thalu_pkg::DATA_W:1];
               carry_out = asr_wide[0];
            end
            default: begin
               value_out = ror_res;
               carry_out = ror_res[thalu_pkg::DATA_W-1];
            end
         endcase
      end
   end

endmodule

FILE: design/thalu_exec.sv
// decode and single-pass execute of thumb formats 1 to 4
module thalu_exec (
   input  logic [thalu_pkg::INSTR_W-1:0] instruction,
   input  logic [thalu_pkg::DATA_W-1:0]  op_a,
   input  logic [thalu_pkg::DATA_W-1:0]  op_b,
   input  thalu_pkg::flags_type          flags_in,
   output thalu_pkg::exec_result_type    result
);

   localparam int W = thalu_pkg::DATA_W;

   thalu_pkg::format_type     fmt;
   thalu_pkg::alu_op_type     alu_op;
   thalu_pkg::imm_op_type     imm_op;
   thalu_pkg::shift_kind_type sh_kind;
   logic [thalu_pkg::AMT_W-1:0] sh_amount;
   logic [W-1:0]              sh_value;
   logic [W-1:0]              sh_out;
   logic                      sh_carry;
   logic [W-1:0]              add_a;
   logic [W-1:0]              add_b;
   logic                      add_cin;
   logic [W:0]                sum;
   logic [W-1:0]              sum_ovf;
   logic [W-1:0]              product;
   logic [W-1:0]              res;
   logic [W-1:0]              b_raw;

   assign fmt    = thalu_pkg::decode_format(instruction);
   assign alu_op = thalu_pkg::alu_op_type'(instruction[9:6]);
   assign imm_op = thalu_pkg::imm_op_type'(instruction[12:11]);

   // shifter operands
   always_comb begin
      if (fmt == thalu_pkg::FMT_ALU) begin
         sh_value  = op_b;
         sh_amount = op_a[thalu_pkg::AMT_W-1:0];
         case (alu_op)
            thalu_pkg::ALU_LSL: sh_kind = thalu_pkg::SHIFT_LSL;
            thalu_pkg::ALU_LSR: sh_kind = thalu_pkg::SHIFT_LSR;
            thalu_pkg::ALU_ASR: sh_kind = thalu_pkg::SHIFT_ASR;
            default:            sh_kind = thalu_pkg::SHIFT_ROR;
         endcase
      end else begin
         sh_value  = op_a;
         sh_kind   = thalu_pkg::shift_kind_type'(instruction[12:11]);
         // lsr #0 and asr #0 encode a full-width shift
         if (sh_kind != thalu_pkg::SHIFT_LSL && instruction[10:6] == '0) begin
            sh_amount = thalu_pkg::AMT_W'(W);
         end else begin
            sh_amount = thalu_pkg::AMT_W'(instruction[10:6]);
         end
      end
   end

   thalu_shifter u_shifter (
      .kind      (sh_kind),
      .amount    (sh_amount),
      .value     (sh_value),
      .carry_in  (flags_in.c),
      .value_out (sh_out),
      .carry_out (sh_carry)
   );

   // adder operands, subtraction as a + ~b + carry
   always_comb begin
      add_a   = op_b;
      add_b   = op_a;
      add_cin = 1'b0;
      b_raw   = op_b;
      case (fmt)
         thalu_pkg::FMT_ADD_SUB: begin
            add_a = op_a;
            b_raw = instruction[10] ? W'(instruction[8:6]) : op_b;
            add_b = instruction[9] ? ~b_raw : b_raw;
            add_cin = instruction[9];
         end
         thalu_pkg::FMT_IMM8: begin
            add_a = op_b;
            b_raw = W'(instruction[7:0]);
            if (imm_op == thalu_pkg::IMM_CMP || imm_op == thalu_pkg::IMM_SUB) begin
               add_b   = ~b_raw;
               add_cin = 1'b1;
            end else begin
               add_b = b_raw;
            end
         end
         thalu_pkg::FMT_ALU: begin
            case (alu_op)
               thalu_pkg::ALU_ADC: add_cin = flags_in.c;
               thalu_pkg::ALU_SBC: begin
                  add_b   = ~op_a;
                  add_cin = flags_in.c;
               end
               thalu_pkg::ALU_NEG: begin
                  add_a   = '0;
                  add_b   = ~op_a;
                  add_cin = 1'b1;
               end
               thalu_pkg::ALU_CMP: begin
                  add_b   = ~op_a;
                  add_cin = 1'b1;
               end
               default: add_b = op_a;
            endcase
         end
         default: add_b = op_a;
      endcase
   end

   assign sum     = {1'b0, add_a} + {1'b0, add_b} + (W+1)'(add_cin);
   assign sum_ovf = ~(add_a ^ add_b) & (add_a ^ sum[W-1:0]);
   // only the low word of the product is kept
   assign product = op_b * op_a;

   always_comb begin
      result.executed   = 1'b1;
      result.written    = 1'b1;
      result.dest_index = instruction[2:0];
      result.flags      = flags_in;
      res               = '0;
      case (fmt)
         thalu_pkg::FMT_SHIFT_IMM: begin
            res            = sh_out;
            result.flags.c = sh_carry;
         end
         thalu_pkg::FMT_ADD_SUB: begin
            res            = sum[W-1:0];
            result.flags.c = sum[W];
            result.flags.v = sum_ovf[W-1];
         end
         thalu_pkg::FMT_IMM8: begin
            result.dest_index = instruction[10:8];
            if (imm_op == thalu_pkg::IMM_MOV) begin
               res = W'(instruction[7:0]);
            end else begin
               res            = sum[W-1:0];
               result.flags.c = sum[W];
               result.flags.v = sum_ovf[W-1];
               result.written = imm_op != thalu_pkg::IMM_CMP;
            end
         end
         thalu_pkg::FMT_ALU: begin
            case (alu_op)
               thalu_pkg::ALU_AND, thalu_pkg::ALU_TST: res = op_b & op_a;
               thalu_pkg::ALU_EOR: res = op_b ^ op_a;
               thalu_pkg::ALU_ORR: res = op_b | op_a;
               thalu_pkg::ALU_BIC: res = op_b & ~op_a;
               thalu_pkg::ALU_MVN: res = ~op_a;
               thalu_pkg::ALU_MUL: begin
                  res            = product;
                  result.flags.c = 1'b0;
               end
               default: res = sum[W-1:0];
            endcase
            if (alu_op inside {thalu_pkg::ALU_LSL, thalu_pkg::ALU_LSR,
                               thalu_pkg::ALU_ASR, thalu_pkg::ALU_ROR}) begin
               res            = sh_out;
               result.flags.c = sh_carry;
            end
            if (alu_op inside {thalu_pkg::ALU_ADC, thalu_pkg::ALU_SBC, thalu_pkg::ALU_NEG,
                               thalu_pkg::ALU_CMP, thalu_pkg::ALU_CMN}) begin
               result.flags.c = sum[W];
               result.flags.v = sum_ovf[W-1];
            end
            result.written = !(alu_op inside {thalu_pkg::ALU_TST, thalu_pkg::ALU_CMP,
                                              thalu_pkg::ALU_CMN});
         end
         default: begin
            result.executed   = 1'b0;
            result.written    = 1'b0;
            result.dest_index = '0;
         end
      endcase
      result.value = res;
      if (fmt != thalu_pkg::FMT_NONE) begin
         result.flags.n = res[W-1];
         result.flags.z = res == '0;
      end
   end

endmodule

FILE: design/thumb_alu_execute_top.sv
// top level of the thumb alu execute block: operand fetch, execute, write-back
//
//   channel  | ports                         | direction | moves
//   ---------+-------------------------------+-----------+-------------------------------
//   request  | req_valid, req_stall, req_*   | in        | one instruction halfword item
//   response | rsp_valid, rsp_stall, rsp_*   | out       | one result item with new flags
//
// one item per cycle sustained while rsp_stall is low; an item accepted at one edge is
// executed from the input register and its result shows on rsp_ once it is loaded
// into the result register; the single execute pass (shifter, adder or multiplier) lies
// between the input register and the result register, with write-back at the same edge
// synchronous reset clears the register valid bits, the flags and both stage valids
// rsp_stall holds the result register; the input stage takes one more item, then
// req_stall stays high until the result register drains
module thumb_alu_execute_top (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [thalu_pkg::INSTR_W-1:0] req_instruction,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic                          rsp_executed,
   output logic                          rsp_dest_written,
   output logic [thalu_pkg::REG_IDX_W-1:0] rsp_dest_index,
   output logic [thalu_pkg::DATA_W-1:0]  rsp_result_value,
   output logic                          rsp_flag_n,
   output logic                          rsp_flag_z,
   output logic                          rsp_flag_c,
   output logic                          rsp_flag_v
);

`include "thumb_alu_execute_top_macros.svh"

   localparam int W  = thalu_pkg::DATA_W;
   localparam int IW = thalu_pkg::REG_IDX_W;

   // low register file, read at accept time, written at execute
   logic [W-1:0]                    regs_mem_ff [thalu_pkg::REG_COUNT];
   logic [thalu_pkg::REG_COUNT-1:0] reg_valid_ff;
   logic [thalu_pkg::REG_COUNT-1:0] reg_valid_in;

   // input stage
   logic                          in_valid_ff;
   logic                          in_valid_in;
   logic [thalu_pkg::INSTR_W-1:0] in_instr_ff;
   logic [W-1:0]                  op_a_ff;
   logic [W-1:0]                  op_b_ff;
   logic                          a_valid_ff;
   logic                          b_valid_ff;
   logic                          fwd_a_ff;
   logic                          fwd_b_ff;

   // result stage and flags
   logic                          rsp_valid_ff;
   logic                          rsp_valid_in;
   thalu_pkg::exec_result_type    rsp_ff;
   thalu_pkg::flags_type          flags_ff;

   logic                          accept;
   logic                          out_free;
   logic                          load_out;
   logic                          commit_we;
   logic [IW-1:0]                 addr_a;
   logic [IW-1:0]                 addr_b;
   logic [W-1:0]                  op_a;
   logic [W-1:0]                  op_b;
   thalu_pkg::exec_result_type    exec_res;

   // handshake: the input stage moves on whenever the result register is free or draining
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign load_out  = in_valid_ff && out_free;
   assign req_stall = in_valid_ff && !out_free;
   assign accept    = req_valid && !req_stall;
   assign commit_we = load_out && exec_res.written;

   assign in_valid_in  = accept ? 1'b1 : (load_out ? 1'b0 : in_valid_ff);
   assign rsp_valid_in = load_out ? 1'b1 : (rsp_stall ? rsp_valid_ff : 1'b0);

   always_comb begin
      reg_valid_in = reg_valid_ff;
      if (commit_we) begin
         reg_valid_in[exec_res.dest_index] = 1'b1;
      end
   end

   // read addresses come straight from the incoming halfword
   assign addr_a = req_instruction[5:3];
   assign addr_b = thalu_pkg::port_b_index(req_instruction);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         reg_valid_ff <= '0;
         flags_ff     <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         reg_valid_ff <= reg_valid_in;
         if (load_out) begin
            flags_ff <= exec_res.flags;
         end
      end
   end

   // register file write port
   always_ff @(posedge clock) begin
      if (commit_we) begin
         regs_mem_ff[exec_res.dest_index] <= exec_res.value;
      end
   end

   // operand read at accept; a write landing at the same edge is caught by the forward flags
   always_ff @(posedge clock) begin
      if (accept) begin
         in_instr_ff <= req_instruction;
         op_a_ff     <= regs_mem_ff[addr_a];
         op_b_ff     <= regs_mem_ff[addr_b];
         a_valid_ff  <= reg_valid_ff[addr_a];
         b_valid_ff  <= reg_valid_ff[addr_b];
         fwd_a_ff    <= commit_we && exec_res.dest_index == addr_a;
         fwd_b_ff    <= commit_we && exec_res.dest_index == addr_b;
      end
   end

   // the result register holds the last value written back while the item waits here
   assign op_a = fwd_a_ff ? rsp_ff.value : (a_valid_ff ? op_a_ff : '0);
   assign op_b = fwd_b_ff ? rsp_ff.value : (b_valid_ff ? op_b_ff : '0);

   thalu_exec u_exec (
      .instruction (in_instr_ff),
      .op_a        (op_a),
      .op_b        (op_b),
      .flags_in    (flags_ff),
      .result      (exec_res)
   );

   always_ff @(posedge clock) begin
      if (load_out) begin
         rsp_ff <= exec_res;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_executed     = rsp_ff.executed;
   assign rsp_dest_written = rsp_ff.written;
   assign rsp_dest_index   = rsp_ff.dest_index;
   assign rsp_result_value = rsp_ff.value;
   assign rsp_flag_n       = rsp_ff.flags.n;
   assign rsp_flag_z       = rsp_ff.flags.z;
   assign rsp_flag_c       = rsp_ff.flags.c;
   assign rsp_flag_v       = rsp_ff.flags.v;

   // back-pressure only ever comes from a held item in the input stage
   `THALU_ASSERT_NOW(a_stall_needs_item, clock, reset, req_stall, in_valid_ff,
                     "stall with empty input stage")

   // after an execute the flag state matches the flags reported with that item
   `THALU_ASSERT_NEXT(a_flags_follow_rsp, clock, reset, load_out,
                      rsp_valid_ff && flags_ff == rsp_ff.flags,
                      "flag state differs from reported flags")

   // an encoding outside the formats writes nothing and reports a zero value
   `THALU_ASSERT_NOW(a_unexecuted_quiet, clock, reset, rsp_valid_ff && !rsp_ff.executed,
                     !rsp_ff.written && rsp_ff.value == '0 && rsp_ff.dest_index == '0,
                     "unexecuted item reports a write")

endmodule
